FILE: sv/tile_block_palette_attribute_defines.svh
// Assertion macros shared by the checker of the palette attribute block.
// Depends on nothing; include by bare file name.
`ifndef TILE_BLOCK_PALETTE_ATTRIBUTE_DEFINES_SVH
`define TILE_BLOCK_PALETTE_ATTRIBUTE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBPA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tbpa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TBPA_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tbpa assertion failed");

`endif

FILE: sv/tbpa_pkg.sv
// Types, codes and reset constants of the palette attribute block.
// No dependencies; design uses scoped names, testbench imports it.
`default_nettype none

package tbpa_pkg;

  localparam int unsigned ApbAddrW = 4;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_NO_FIT   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_BACKGROUND = 2'd0,
    REG_PALETTE0   = 2'd1,
    REG_PALETTE1   = 2'd2,
    REG_PALETTE2   = 2'd3
  } reg_idx_e;

  localparam logic [7:0]  BgReset       = 8'd12;
  localparam logic [23:0] Palette0Reset = 24'h1C0D38;
  localparam logic [23:0] Palette1Reset = 24'h2A0D25;
  localparam logic [23:0] Palette2Reset = 24'hFF1B20;

  typedef struct packed {
    logic [7:0]       bg;
    logic [2:0][23:0] pal;
  } cfg_t;

  // Outcome of one block, as decided in the first stage.
  typedef struct packed {
    status_e    status;
    logic [1:0] pal;
    logic [5:0] addr;
    logic [7:0] orbits;
  } pick_t;

  typedef struct packed {
    status_e    status;
    logic [1:0] pal;
    logic [5:0] addr;
    logic [7:0] value;
  } result_t;

  function automatic logic palette_has(logic [23:0] pal, logic [7:0] c);
    return (pal[7:0] == c) || (pal[15:8] == c) || (pal[23:16] == c);
  endfunction

endpackage

`default_nettype wire

FILE: sv/tbpa_regs.sv
// APB configuration registers: background colour and three palettes.
// Depends on tbpa_pkg.
`default_nettype none

module tbpa_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tbpa_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output tbpa_pkg::cfg_t                        cfg_o
);

  tbpa_pkg::cfg_t   cfg_q;
  tbpa_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = tbpa_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bg     <= tbpa_pkg::BgReset;
      cfg_q.pal[0] <= tbpa_pkg::Palette0Reset;
      cfg_q.pal[1] <= tbpa_pkg::Palette1Reset;
      cfg_q.pal[2] <= tbpa_pkg::Palette2Reset;
    end else if (wr_en) begin
      case (idx)
        tbpa_pkg::REG_BACKGROUND: cfg_q.bg     <= pwdata[7:0];
        tbpa_pkg::REG_PALETTE0:   cfg_q.pal[0] <= pwdata[23:0];
        tbpa_pkg::REG_PALETTE1:   cfg_q.pal[1] <= pwdata[23:0];
        tbpa_pkg::REG_PALETTE2:   cfg_q.pal[2] <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tbpa_pkg::REG_BACKGROUND: prdata = {24'd0, cfg_q.bg};
      tbpa_pkg::REG_PALETTE0:   prdata = {8'd0, cfg_q.pal[0]};
      tbpa_pkg::REG_PALETTE1:   prdata = {8'd0, cfg_q.pal[1]};
      tbpa_pkg::REG_PALETTE2:   prdata = {8'd0, cfg_q.pal[2]};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/tbpa_collect.sv
// Colour collection for the current block and palette choice on its last pixel.
// Depends on tbpa_pkg.
`default_nettype none

module tbpa_collect (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tbpa_pkg::cfg_t cfg_i,
  input  wire logic           adv_i,
  input  wire logic [7:0]     pixel_i,
  input  wire logic [3:0]     col_i,
  input  wire logic [3:0]     row_i,
  input  wire logic           last_i,
  output tbpa_pkg::pick_t     pick_o
);

  logic [1:0]       cnt_q, cnt_d, cnt_t;
  logic [2:0][7:0]  seen_q, seen_d, seen_t;
  logic             ovf_q, ovf_d, ovf_t;
  logic             is_bg, hit;
  logic [2:0]       fit;
  logic [2:0]       sh;

  always_comb begin
    is_bg = (pixel_i == cfg_i.bg);
    hit   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((2'(i) < cnt_q) && (seen_q[i] == pixel_i)) hit = 1'b1;
    end

    seen_t = seen_q;
    cnt_t  = cnt_q;
    ovf_t  = ovf_q;
    if (!is_bg && !hit) begin
      if (cnt_q == 2'd3) begin
        ovf_t = 1'b1;
      end else begin
        seen_t[cnt_q] = pixel_i;
        cnt_t         = cnt_q + 2'd1;
      end
    end

    // Palette p fits when it holds every collected colour.
    for (int p = 0; p < 3; p++) begin
      fit[p] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if ((2'(i) < cnt_t) && !tbpa_pkg::palette_has(cfg_i.pal[p], seen_t[i])) begin
          fit[p] = 1'b0;
        end
      end
    end

    pick_o.pal = 2'd0;
    if (ovf_t) begin
      pick_o.status = tbpa_pkg::STATUS_OVERFLOW;
    end else if (fit[0]) begin
      pick_o.status = tbpa_pkg::STATUS_OK;
    end else if (fit[1]) begin
      pick_o.status = tbpa_pkg::STATUS_OK;
      pick_o.pal    = 2'd1;
    end else if (fit[2]) begin
      pick_o.status = tbpa_pkg::STATUS_OK;
      pick_o.pal    = 2'd2;
    end else begin
      pick_o.status = tbpa_pkg::STATUS_NO_FIT;
    end

    sh            = {row_i[0], col_i[0], 1'b0};
    pick_o.addr   = {row_i[3:1], col_i[3:1]};
    pick_o.orbits = {6'd0, pick_o.pal} << sh;
  end

  // Clear the collection once the block's last pixel is consumed.
  always_comb begin
    cnt_d  = cnt_q;
    seen_d = seen_q;
    ovf_d  = ovf_q;
    if (adv_i) begin
      if (last_i) begin
        cnt_d  = 2'd0;
        seen_d = '0;
        ovf_d  = 1'b0;
      end else begin
        cnt_d  = cnt_t;
        seen_d = seen_t;
        ovf_d  = ovf_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      seen_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tbpa_attr_table.sv
// Attribute table memory with per-entry valid bits and the read-modify-write stage.
// Depends on tbpa_pkg.
`default_nettype none

module tbpa_attr_table #(
  parameter int unsigned ATTR_ENTRIES = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire tbpa_pkg::pick_t pick_i,
  input  wire logic            take_i,
  output logic                 valid_o,
  output tbpa_pkg::result_t    res_o
);

  localparam int unsigned SlotW   = (ATTR_ENTRIES > 1) ? $clog2(ATTR_ENTRIES) : 1;
  localparam logic [8:0]  EntriesW = 9'(ATTR_ENTRIES);

  logic [7:0]              mem_q [ATTR_ENTRIES];
  logic [ATTR_ENTRIES-1:0] vld_q;

  logic                    s2_valid_q;
  tbpa_pkg::pick_t         pick_q;
  logic [SlotW-1:0]        slot_q;
  logic [7:0]              rd_data_q;
  logic                    rd_vld_q;
  logic                    byp_q;
  logic [7:0]              byp_data_q;

  logic [8:0]              red;
  logic [SlotW-1:0]        rd_slot;
  logic [7:0]              old_val;
  logic [7:0]              wr_data;
  logic                    wr_en;

  // Table slot is the address modulo the table size when ATTR_ENTRIES is 13 or more.
  always_comb begin
    red = {3'd0, pick_i.addr};
    for (int k = 0; k < 4; k++) begin
      if (red >= EntriesW) red = red - EntriesW;
    end
    rd_slot = red[SlotW-1:0];
  end

  assign old_val = byp_q ? byp_data_q : (rd_vld_q ? rd_data_q : 8'd0);
  assign wr_en   = take_i && (pick_q.status == tbpa_pkg::STATUS_OK);
  assign wr_data = old_val | pick_q.orbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      vld_q      <= '0;
    end else begin
      if (load_i) begin
        s2_valid_q <= 1'b1;
      end else if (take_i) begin
        s2_valid_q <= 1'b0;
      end
      if (wr_en) vld_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[slot_q] <= wr_data;
    if (load_i) begin
      rd_data_q  <= mem_q[rd_slot];
      rd_vld_q   <= vld_q[rd_slot];
      // Forward a write to the same slot that lands on the read edge.
      byp_q      <= wr_en && (slot_q == rd_slot);
      byp_data_q <= wr_data;
      pick_q     <= pick_i;
      slot_q     <= rd_slot;
    end
  end

  assign valid_o       = s2_valid_q;
  assign res_o.status  = pick_q.status;
  assign res_o.pal     = pick_q.pal;
  assign res_o.addr    = pick_q.addr;
  assign res_o.value   = (pick_q.status == tbpa_pkg::STATUS_OK) ? wr_data : old_val;

endmodule

`default_nettype wire

FILE: sv/tile_block_palette_attribute.sv
// Path: input register, table stage, output register. Throughput: one pixel per
// cycle unless the output is back-pressured; the table read-modify-write is split
// over two stages with a forward path, so back-to-back blocks to one slot do not
// stall. Reset: collection state, registers and table valid bits clear at once; the
// table reads as zero until written, with no clearing sweep.
`default_nettype none

module tile_block_palette_attribute #(
  parameter int unsigned ATTR_ENTRIES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tbpa_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    pixel_color_i,
  input  wire logic [3:0]                    block_col_i,
  input  wire logic [3:0]                    block_row_i,
  input  wire logic                          last_pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         status_o,
  output logic [1:0]                         palette_index_o,
  output logic [5:0]                         attribute_address_o,
  output logic [7:0]                         attribute_value_o
);

  tbpa_pkg::cfg_t    cfg;
  tbpa_pkg::pick_t   pick;
  tbpa_pkg::result_t s2_res;

  logic       s1_valid_q;
  logic [7:0] s1_pixel_q;
  logic [3:0] s1_col_q;
  logic [3:0] s1_row_q;
  logic       s1_last_q;
  logic       s1_adv;
  logic       s2_valid;
  logic       s2_ready;
  logic       s2_take;
  logic       in_xfer;

  logic              out_valid_q;
  tbpa_pkg::result_t out_q;

  tbpa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pixels without the last flag drain without touching later stages.
  assign s2_ready   = !s2_valid || s2_take;
  assign s1_adv     = s1_valid_q && (!s1_last_q || s2_ready);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s2_take    = s2_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pixel_q <= pixel_color_i;
      s1_col_q   <= block_col_i;
      s1_row_q   <= block_row_i;
      s1_last_q  <= last_pixel_i;
    end
    if (s2_take) out_q <= s2_res;
  end

  tbpa_collect u_collect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .adv_i   (s1_adv),
    .pixel_i (s1_pixel_q),
    .col_i   (s1_col_q),
    .row_i   (s1_row_q),
    .last_i  (s1_last_q),
    .pick_o  (pick)
  );

  tbpa_attr_table #(
    .ATTR_ENTRIES (ATTR_ENTRIES)
  ) u_attr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_adv && s1_last_q),
    .pick_i  (pick),
    .take_i  (s2_take),
    .valid_o (s2_valid),
    .res_o   (s2_res)
  );

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign palette_index_o     = out_q.pal;
  assign attribute_address_o = out_q.addr;
  assign attribute_value_o   = out_q.value;

endmodule

`default_nettype wire

FILE: sv/tbpa_checker.sv
// Port-level checks of the palette attribute block, bound to the top level.
// Depends on tbpa_pkg and tile_block_palette_attribute_defines.svh.
`default_nettype none

`include "tile_block_palette_attribute_defines.svh"

module tbpa_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] status_o,
  input wire logic [1:0] palette_index_o,
  input wire logic [5:0] attribute_address_o,
  input wire logic [7:0] attribute_value_o
);

  `TBPA_ASSERT_IMP(a_status_code, clk_i, rst_ni, out_valid_o, status_o != 2'd3)

  `TBPA_ASSERT_IMP(a_error_pal_zero, clk_i, rst_ni, out_valid_o && (status_o != tbpa_pkg::STATUS_OK), palette_index_o == 2'd0)

  `TBPA_ASSERT_IMP(a_pal_range, clk_i, rst_ni, out_valid_o, palette_index_o != 2'd3)

  `TBPA_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(attribute_value_o) && $stable(attribute_address_o))

endmodule

bind tile_block_palette_attribute tbpa_checker u_tbpa_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_o            (status_o),
  .palette_index_o     (palette_index_o),
  .attribute_address_o (attribute_address_o),
  .attribute_value_o   (attribute_value_o)
);

`default_nettype wire

FILE: dv/tb_tile_block_palette_attribute.sv
// Self-checking testbench of the palette attribute block: directed probe table, then
// random pixel blocks under several register settings. Valid/ready stalls are random.
// Depends on tbpa_pkg and tile_block_palette_attribute.
module tb_tile_block_palette_attribute;
  timeunit 1ns;
  timeprecision 1ps;
  import tbpa_pkg::*;

  localparam int unsigned AttrEntries  = 64;
  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 220;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned NumProbes    = 25;

  typedef enum logic [1:0] {MIX_FIT, MIX_BLEND, MIX_WILD} mix_e;

  typedef struct packed {
    logic [7:0] pix;
    logic [3:0] col;
    logic [3:0] row;
    logic       last;
    logic       typed;
    result_t    want;
  } probe_t;

  localparam result_t NoResult = '{STATUS_OK, 2'd0, 6'd0, 8'd0};

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          pixel_color_i;
  logic [3:0]          block_col_i;
  logic [3:0]          block_row_i;
  logic                last_pixel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [1:0]          status_o;
  logic [1:0]          palette_index_o;
  logic [5:0]          attribute_address_o;
  logic [7:0]          attribute_value_o;

  tile_block_palette_attribute #(.ATTR_ENTRIES(AttrEntries)) u_top (.*);

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predictor state: registers, collected colors and attribute table.
  cfg_t        palette_cfg;
  logic [7:0]  seen_q [3];
  int unsigned ncolors;
  logic        overflow_q;
  logic [7:0]  attr_mem [AttrEntries];
  result_t     pending_attrs [$];
  result_t     want_attr;

  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_idle;
  bit          rx_idle;
  bit          quiet;

  probe_t probes [NumProbes] = '{
    '{8'd12,  4'd0,  4'd0,  1'b1, 1'b1, '{STATUS_OK,       2'd0, 6'd0,  8'h00}},
    '{8'd56,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd13,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd28,  4'd15, 4'd14, 1'b1, 1'b1, '{STATUS_OK,       2'd0, 6'd63, 8'h00}},
    '{8'd37,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd13,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd42,  4'd1,  4'd1,  1'b1, 1'b1, '{STATUS_OK,       2'd1, 6'd0,  8'h40}},
    '{8'd32,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd27,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd255, 4'd0,  4'd15, 1'b1, 1'b1, '{STATUS_OK,       2'd2, 6'd56, 8'h20}},
    '{8'd56,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd13,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd28,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd37,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd200, 4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd28,  4'd14, 4'd0,  1'b1, 1'b1, '{STATUS_OVERFLOW, 2'd0, 6'd7,  8'h00}},
    '{8'd56,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd37,  4'd2,  4'd4,  1'b1, 1'b1, '{STATUS_NO_FIT,   2'd0, 6'd17, 8'h00}},
    '{8'd13,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd12,  4'd0,  4'd0,  1'b0, 1'b0, NoResult},
    '{8'd13,  4'd0,  4'd0,  1'b1, 1'b0, NoResult},
    '{8'd255, 4'd1,  4'd1,  1'b1, 1'b0, NoResult},
    '{8'd0,   4'd0,  4'd0,  1'b1, 1'b1, '{STATUS_NO_FIT,   2'd0, 6'd0,  8'hC0}},
    '{8'd255, 4'd15, 4'd15, 1'b0, 1'b0, NoResult},
    '{8'd0,   4'd15, 4'd15, 1'b1, 1'b1, '{STATUS_NO_FIT,   2'd0, 6'd63, 8'h00}}
  };

  // Collect one pixel; on the block's last pixel pick a palette and update the table.
  function automatic bit predict_attr(input logic [7:0] c, input logic [3:0] col,
                                      input logic [3:0] row, input logic last,
                                      output result_t res);
    bit         known;
    bit         found;
    bit         fits;
    bit         held;
    logic [5:0] slot;
    logic [1:0] pick;
    status_e    st;
    known = (c == palette_cfg.bg);
    for (int i = 0; i < 3; i++)
      if (i < ncolors && seen_q[i] == c) known = 1'b1;
    if (!known) begin
      if (ncolors == 3) overflow_q = 1'b1;
      else begin
        seen_q[ncolors] = c;
        ncolors++;
      end
    end
    res = NoResult;
    if (!last) return 1'b0;

    slot  = {row[3:1], col[3:1]};
    pick  = 2'd0;
    found = 1'b0;
    st    = STATUS_OK;
    if (overflow_q) st = STATUS_OVERFLOW;
    else begin
      for (int p = 0; p < 3; p++) begin
        fits = 1'b1;
        for (int i = 0; i < 3; i++) begin
          held = 1'b0;
          for (int b = 0; b < 3; b++)
            if (palette_cfg.pal[p][8*b +: 8] == seen_q[i]) held = 1'b1;
          if (i < ncolors && !held) fits = 1'b0;
        end
        if (fits && !found) begin
          found = 1'b1;
          pick  = 2'(p);
        end
      end
      if (!found) st = STATUS_NO_FIT;
    end

    // Odd row selects the upper nibble, odd column the upper pair within it.
    if (st == STATUS_OK) attr_mem[slot] |= {6'd0, pick} << {row[0], col[0], 1'b0};
    else pick = 2'd0;
    res = '{st, pick, slot, attr_mem[slot]};

    ncolors    = 0;
    overflow_q = 1'b0;
    seen_q     = '{default: 8'd0};
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp,
                                      input logic [7:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
      mismatches++;
    end
  endfunction

  // Entered in the time step of a clock edge; returns in the step of the transfer.
  task automatic send_pixel(input logic [7:0] c, input logic [3:0] col,
                            input logic [3:0] row, input logic last,
                            input logic typed, input result_t want);
    int unsigned gap;
    result_t     res;
    gap = (tx_idle && !quiet) ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_color_i <= c;
    block_col_i   <= col;
    block_row_i   <= row;
    last_pixel_i  <= last;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    if (predict_attr(c, col, row, last, res)) pending_attrs.push_back(typed ? want : res);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_attrs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_BACKGROUND: palette_cfg.bg     = val[7:0];
      REG_PALETTE0:   palette_cfg.pal[0] = val[23:0];
      REG_PALETTE1:   palette_cfg.pal[1] = val[23:0];
      REG_PALETTE2:   palette_cfg.pal[2] = val[23:0];
    endcase
  endtask

  task automatic load_palettes(input cfg_t c);
    write_reg(REG_BACKGROUND, {24'd0, c.bg});
    write_reg(REG_PALETTE0, {8'd0, c.pal[0]});
    write_reg(REG_PALETTE1, {8'd0, c.pal[1]});
    write_reg(REG_PALETTE2, {8'd0, c.pal[2]});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly blocks that fit one palette; some blends of two palettes and some noise.
  task automatic run_block(input int unsigned n);
    mix_e        mix;
    int unsigned p;
    int unsigned r;
    logic [7:0]  c;
    r     = $urandom_range(0, 9);
    mix   = (r < 6) ? MIX_FIT : (r < 8) ? MIX_BLEND : MIX_WILD;
    p     = $urandom_range(0, 2);
    quiet = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 7);
      case (mix)
        MIX_FIT:
          c = (r < 6) ? palette_cfg.pal[p][8*(r%3) +: 8] : palette_cfg.bg;
        MIX_BLEND:
          if (r < 3)      c = palette_cfg.pal[p][8*r +: 8];
          else if (r < 6) c = palette_cfg.pal[(p+1)%3][8*(r-3) +: 8];
          else if (r == 6) c = palette_cfg.bg;
          else            c = 8'($urandom_range(0, 255));
        default:
          c = 8'($urandom_range(0, 255));
      endcase
      send_pixel(c, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 (k == n - 1), 1'b0, NoResult);
    end
  endtask

  initial begin
    cfg_t        next_cfg;
    int unsigned sent;
    int unsigned n;
    int unsigned r;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    pixel_color_i = '0;
    block_col_i   = '0;
    block_row_i   = '0;
    last_pixel_i  = 1'b0;
    out_ready_i   = 1'b0;
    palette_cfg.bg     = BgReset;
    palette_cfg.pal[0] = Palette0Reset;
    palette_cfg.pal[1] = Palette1Reset;
    palette_cfg.pal[2] = Palette2Reset;
    seen_q     = '{default: 8'd0};
    ncolors    = 0;
    overflow_q = 1'b0;
    attr_mem   = '{default: 8'd0};
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    quiet      = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i])
      send_pixel(probes[i].pix, probes[i].col, probes[i].row, probes[i].last,
                 probes[i].typed, probes[i].want);

    for (int ph = 1; ph <= NumPhases; ph++) begin
      drain_results();
      repeat (SettleCycles) @(posedge clk_i);
      next_cfg.bg     = 8'($urandom_range(0, 255));
      next_cfg.pal[0] = 24'($urandom());
      next_cfg.pal[1] = 24'($urandom());
      next_cfg.pal[2] = 24'($urandom());
      case (ph)
        1: begin
          next_cfg.bg     = 8'hFF;
          next_cfg.pal[0] = 24'hFFFFFF;
          next_cfg.pal[1] = 24'h000000;
        end
        2: begin
          next_cfg.bg     = 8'h00;
          next_cfg.pal[0] = 24'h000000;
          next_cfg.pal[1] = 24'hFFFFFF;
          next_cfg.pal[2] = 24'h0A0A0A;
        end
        3: next_cfg.bg = next_cfg.pal[0][15:8];
        default: ;
      endcase
      load_palettes(next_cfg);
      tx_idle = (ph % 3 != 1);
      rx_idle = (ph % 3 != 2);

      sent = 0;
      while (sent < PhaseItems) begin
        r = $urandom_range(0, 39);
        if (r == 0)     n = 256;
        else if (r < 5) n = $urandom_range(9, 40);
        else            n = $urandom_range(1, 8);
        run_block(n);
        sent += n;
        // Hold the stream until the output side has caught up.
        if ($urandom_range(0, 29) == 0) drain_results();
      end
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending_attrs.size() == 0)
      $display("tile_block_palette_attribute test passed");
    else
      $display("tile_block_palette_attribute test failed");
    $finish;
  end

  // Result side: when rx_idle is set, drop ready for a random gap before each transfer.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_idle ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_attrs.size() == 0) begin
        $display("%0t: unexpected result: expected none, got status %0d addr %0d",
                 $time, status_o, attribute_address_o);
        mismatches++;
      end else begin
        want_attr = pending_attrs.pop_front();
        check_field("status", 8'(want_attr.status), 8'(status_o));
        check_field("palette_index", 8'(want_attr.pal), 8'(palette_index_o));
        check_field("attribute_address", 8'(want_attr.addr), 8'(attribute_address_o));
        check_field("attribute_value", want_attr.value, attribute_value_o);
      end
    end
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("tile_block_palette_attribute test failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tbpa_pkg.sv
sv/tbpa_regs.sv
sv/tbpa_collect.sv
sv/tbpa_attr_table.sv
sv/tile_block_palette_attribute.sv
sv/tbpa_checker.sv
dv/tb_tile_block_palette_attribute.sv
